[rtl/macs_pkg.sv]
package macs_pkg;

	// Operation codes carried by the input transaction.
	localparam logic [1:0] OP_TICK   = 2'd0;
	localparam logic [1:0] OP_SAMPLE = 2'd1;
	localparam logic [1:0] OP_LOAD   = 2'd2;

	// Configuration register indexes.
	localparam logic [2:0] REG_GEAR_LOWEST  = 3'd0;
	localparam logic [2:0] REG_GEAR_HIGHEST = 3'd1;
	localparam logic [2:0] REG_VRANGE       = 3'd2;
	localparam logic [2:0] REG_TOP_VRANGE   = 3'd3;
	localparam logic [2:0] REG_LOW_THRESH   = 3'd4;
	localparam logic [2:0] REG_HIGH_THRESH  = 3'd5;
	localparam logic [2:0] REG_HOLD_TICKS   = 3'd6;
	localparam logic [2:0] REG_LEAD_TICKS   = 3'd7;

	localparam int CFG_DATA_W = 12;

	typedef struct packed {
		logic [1:0]  operation;
		logic [11:0] sample_code;
		logic [3:0]  point_index;
		logic [2:0]  range_index;
		logic [2:0]  entry_gear;
		logic [11:0] entry_code;
		logic [31:0] entry_coefficient;
	} in_item_t;

	typedef struct packed {
		logic [2:0]  gear;
		logic        gear_changed;
		logic [3:0]  area;
		logic [31:0] coefficient;
	} out_item_t;

	typedef struct packed {
		logic [2:0]  gear;
		logic [11:0] code;
		logic [31:0] coef;
	} cal_entry_t;

	// Result of the shared compare unit for one table entry.
	typedef struct packed {
		logic match;
		logic in_seg;
		logic take_cur;
	} cmp_res_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_EVAL,
		ST_MID,
		ST_STEP,
		ST_COEF,
		ST_DONE
	} state_t;

	typedef enum logic [1:0] {
		CP_SELF,
		CP_UP,
		CP_DOWN,
		CP_END
	} coef_phase_t;

endpackage

[rtl/macs_in_if.sv]
interface macs_in_if import macs_pkg::*; ();
	logic     valid;
	logic     ready;
	in_item_t payload;

	modport source(output valid, output payload, input ready);
	modport sink(input valid, input payload, output ready);
endinterface

[rtl/macs_out_if.sv]
interface macs_out_if import macs_pkg::*; ();
	logic      valid;
	logic      ready;
	out_item_t payload;

	modport source(output valid, output payload, input ready);
	modport sink(input valid, input payload, output ready);
endinterface

[rtl/meter_autorange_calibration_select.sv]
// Flow: a tick or a load is finished when it is accepted; a sample makes up to two passes over the
// calibration points through the table's single read port, then, when the hold timer allows, a walk
// of up to RANGE_COUNT ranges, and waits while the result register is still full.
// Throughput: one transaction at a time; the input is not ready while a sample is worked.
// Reset: arst_n clears control state, the hold timer, gear, held coefficient and loads
// the register defaults; the calibration table is not cleared.
module meter_autorange_calibration_select import macs_pkg::*; #(
	parameter int CAL_POINT_COUNT = 16,
	parameter int RANGE_COUNT     = 8,
	parameter int DEAD_BAND       = 3
) (
	input  logic                  clk,
	input  logic                  arst_n,
	macs_in_if.sink               in_ch,
	macs_out_if.source            out_ch,
	input  logic                  cfg_we,
	input  logic [2:0]            cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);
	localparam int PW    = $clog2(CAL_POINT_COUNT);
	localparam int RW    = (RANGE_COUNT > 1) ? $clog2(RANGE_COUNT) : 1;
	localparam int AW    = PW + RW;
	localparam int DEPTH = 1 << AW;
	localparam logic [6:0]  PCNT    = 7'(CAL_POINT_COUNT);
	localparam logic [4:0]  RCNT    = 5'(RANGE_COUNT);
	localparam logic [PW-1:0] PLAST = PW'(CAL_POINT_COUNT - 1);
	localparam logic [RW-1:0] RLAST = RW'(RANGE_COUNT - 1);

	// Configuration registers.
	logic [2:0]  gear_lo_q, gear_hi_q, vr_q, top_vr_q;
	logic [11:0] low_th_q, high_th_q;
	logic [7:0]  hold_ticks_q, lead_ticks_q;

	// Architectural state.
	logic [7:0]  hold_q;
	logic [2:0]  gear_q;
	logic [31:0] coef_q;

	state_t state_q, state_d;

	// Per-sample working registers.
	logic [11:0]   code_q;
	logic          changed_q;
	logic [PW:0]   n_q, mcnt_q;
	logic [PW-1:0] first_idx_q, prev_idx_q, brk_idx_q, area_q;
	logic [11:0]   first_val_q, prev_val_q;
	logic          brk_q;
	logic [PW-1:0] issue_pt_q;
	logic          issue_on_q;
	logic [RW-1:0] cr_q;
	coef_phase_t   cph_q;
	logic          hit_q;

	// Table read pipeline.
	cal_entry_t    mem [DEPTH];
	cal_entry_t    rd_data_s1;
	logic          rd_v_s1, rd_last_s1;
	logic [PW-1:0] rd_tag_s1;

	// Output register.
	logic      ov_q;
	out_item_t opay_q;

	// Control decoded from the state.
	logic          in_ready, issue_scan, issue_coef, out_load;
	logic [AW-1:0] rd_addr, wr_addr;
	logic          wr_en;
	logic          in_fire, in_sample;
	logic          vr_ok;
	logic          need_mid;
	logic          hold_ok;
	logic [2:0]    cmp_gear;
	cmp_res_t      cmp;

	// Next coefficient candidate range and whether the current one is the last.
	coef_phase_t   cph_d;
	logic [RW-1:0] cr_d;
	logic [4:0]    cr_inc;

	assign in_fire   = in_ch.valid && in_ready;
	assign in_sample = in_fire && (in_ch.payload.operation == OP_SAMPLE);
	assign vr_ok     = (5'(vr_q) < RCNT);
	assign hold_ok   = (hold_q <= lead_ticks_q);
	assign wr_en     = in_fire && (in_ch.payload.operation == OP_LOAD)
		&& (7'(in_ch.payload.point_index) < PCNT)
		&& (5'(in_ch.payload.range_index) < RCNT);
	assign wr_addr   = {PW'(in_ch.payload.point_index), RW'(in_ch.payload.range_index)};

	// The scan passes compare against the gear before stepping, the coefficient
	// walk against the gear after stepping.
	assign cmp_gear = gear_q;

	macs_cmp #(.DEAD_BAND(DEAD_BAND)) u_cmp (
		.entry     (rd_data_s1),
		.want_gear (cmp_gear),
		.code      (code_q),
		.prev_code (prev_val_q),
		.res       (cmp)
	);

	// A second pass is needed only when no end case and no segment settled the area.
	assign need_mid = (n_q >= (PW+1)'(2)) && !(code_q < prev_val_q)
		&& !(code_q > first_val_q) && !brk_q;

	always_comb begin
		cr_inc = 5'(cr_q) + 5'd1;
		cph_d  = CP_END;
		cr_d   = cr_q;
		case (cph_q)
			CP_SELF, CP_UP: begin
				if (cr_inc <= 5'(top_vr_q) && cr_inc < RCNT) begin
					cph_d = CP_UP;
					cr_d  = RW'(cr_inc);
				end else if (vr_q != 3'd0) begin
					cph_d = CP_DOWN;
					cr_d  = RW'(vr_q - 3'd1);
				end
			end
			CP_DOWN: begin
				if (cr_q != '0) begin
					cph_d = CP_DOWN;
					cr_d  = cr_q - RW'(1);
				end
			end
			default: begin
				cph_d = CP_END;
			end
		endcase
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_sample)
					state_d = vr_ok ? ST_SCAN : ST_STEP;
			end
			ST_SCAN: begin
				if (rd_v_s1 && rd_last_s1)
					state_d = ST_EVAL;
			end
			ST_EVAL: begin
				state_d = need_mid ? ST_MID : ST_STEP;
			end
			ST_MID: begin
				if (rd_v_s1 && rd_last_s1)
					state_d = ST_STEP;
			end
			ST_STEP: begin
				state_d = hold_ok ? ST_COEF : ST_DONE;
			end
			ST_COEF: begin
				if (rd_v_s1 && rd_last_s1)
					state_d = ST_DONE;
			end
			ST_DONE: begin
				if (!ov_q || out_ch.ready)
					state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Outputs of the sequencer.
	always_comb begin
		in_ready   = (state_q == ST_IDLE);
		issue_scan = ((state_q == ST_SCAN) || (state_q == ST_MID)) && issue_on_q;
		issue_coef = (state_q == ST_COEF) && (cph_q != CP_END);
		out_load   = (state_q == ST_DONE) && (!ov_q || out_ch.ready);
		if (issue_coef)
			rd_addr = {area_q, cr_q};
		else
			rd_addr = {issue_pt_q, RW'(vr_q)};
	end

	assign in_ch.ready    = in_ready;
	assign out_ch.valid   = ov_q;
	assign out_ch.payload = opay_q;

	// Calibration table: one write port, one registered read port.
	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= '{gear: in_ch.payload.entry_gear,
				code: in_ch.payload.entry_code,
				coef: in_ch.payload.entry_coefficient};
		rd_data_s1 <= mem[rd_addr];
		if (issue_scan) begin
			rd_tag_s1  <= issue_pt_q;
			rd_last_s1 <= (issue_pt_q == PLAST);
		end else begin
			rd_tag_s1  <= issue_pt_q;
			rd_last_s1 <= (cph_d == CP_END);
		end
	end

	// Payload-only working registers of a sample.
	always_ff @(posedge clk) begin
		if (in_sample)
			code_q <= in_ch.payload.sample_code;
		if (out_load)
			opay_q <= '{gear: gear_q, gear_changed: changed_q,
				area: 4'(area_q), coefficient: coef_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gear_lo_q    <= 3'd0;
			gear_hi_q    <= 3'd7;
			vr_q         <= 3'd0;
			top_vr_q     <= 3'd7;
			low_th_q     <= 12'd372;
			high_th_q    <= 12'd3848;
			hold_ticks_q <= 8'd200;
			lead_ticks_q <= 8'd20;
			hold_q       <= '0;
			gear_q       <= '0;
			coef_q       <= '0;
			state_q      <= ST_IDLE;
			changed_q    <= 1'b0;
			n_q          <= '0;
			mcnt_q       <= '0;
			first_idx_q  <= '0;
			prev_idx_q   <= '0;
			brk_idx_q    <= '0;
			area_q       <= '0;
			first_val_q  <= '0;
			prev_val_q   <= '0;
			brk_q        <= 1'b0;
			issue_pt_q   <= '0;
			issue_on_q   <= 1'b0;
			cr_q         <= '0;
			cph_q        <= CP_END;
			hit_q        <= 1'b0;
			rd_v_s1      <= 1'b0;
			ov_q         <= 1'b0;
		end else begin
			state_q <= state_d;
			rd_v_s1 <= issue_scan || issue_coef;

			if (cfg_we) begin
				case (cfg_index)
					REG_GEAR_LOWEST:  gear_lo_q    <= cfg_data[2:0];
					REG_GEAR_HIGHEST: gear_hi_q    <= cfg_data[2:0];
					REG_VRANGE:       vr_q         <= cfg_data[2:0];
					REG_TOP_VRANGE:   top_vr_q     <= cfg_data[2:0];
					REG_LOW_THRESH:   low_th_q     <= cfg_data[11:0];
					REG_HIGH_THRESH:  high_th_q    <= cfg_data[11:0];
					REG_HOLD_TICKS:   hold_ticks_q <= cfg_data[7:0];
					REG_LEAD_TICKS:   lead_ticks_q <= cfg_data[7:0];
					default: begin
					end
				endcase
			end

			// The tick counts the hold timer down to zero.
			if (in_fire && (in_ch.payload.operation == OP_TICK) && (hold_q != 8'd0))
				hold_q <= hold_q - 8'd1;

			if (in_sample) begin
				changed_q  <= 1'b0;
				n_q        <= '0;
				brk_q      <= 1'b0;
				area_q     <= '0;
				issue_pt_q <= '0;
				issue_on_q <= vr_ok;
			end

			// Table walk address counter for both point passes.
			if (issue_scan) begin
				issue_pt_q <= issue_pt_q + PW'(1);
				if (issue_pt_q == PLAST)
					issue_on_q <= 1'b0;
			end

			// First pass: collect the ends of the matching list and the first
			// bracketing segment.
			if (state_q == ST_SCAN && rd_v_s1 && cmp.match) begin
				if (n_q == '0) begin
					first_idx_q <= rd_tag_s1;
					first_val_q <= rd_data_s1.code;
				end else if (!brk_q && cmp.in_seg) begin
					brk_q     <= 1'b1;
					brk_idx_q <= cmp.take_cur ? rd_tag_s1 : prev_idx_q;
				end
				prev_idx_q <= rd_tag_s1;
				prev_val_q <= rd_data_s1.code;
				n_q        <= n_q + (PW+1)'(1);
			end

			if (state_q == ST_EVAL) begin
				mcnt_q     <= '0;
				issue_pt_q <= '0;
				issue_on_q <= need_mid;
				if (n_q == '0)
					area_q <= '0;
				else if (n_q == (PW+1)'(1))
					area_q <= first_idx_q;
				else if (code_q < prev_val_q)
					area_q <= prev_idx_q;
				else if (code_q > first_val_q)
					area_q <= first_idx_q;
				else if (brk_q)
					area_q <= brk_idx_q;
			end

			// Second pass: pick the middle matching point.
			if (state_q == ST_MID && rd_v_s1 && cmp.match) begin
				if (mcnt_q == (n_q >> 1))
					area_q <= rd_tag_s1;
				mcnt_q <= mcnt_q + (PW+1)'(1);
			end

			if (state_q == ST_STEP) begin
				hit_q <= 1'b0;
				if (vr_ok) begin
					cph_q <= CP_SELF;
					cr_q  <= RW'(vr_q);
				end else begin
					cph_q <= CP_DOWN;
					cr_q  <= RLAST;
				end
				if (hold_ok) begin
					if (code_q < low_th_q) begin
						if (gear_q < gear_hi_q) begin
							gear_q    <= gear_q + 3'd1;
							hold_q    <= hold_ticks_q;
							changed_q <= 1'b1;
						end
					end else if (code_q > high_th_q) begin
						if (gear_q > gear_lo_q) begin
							gear_q    <= gear_q - 3'd1;
							hold_q    <= hold_ticks_q;
							changed_q <= 1'b1;
						end
					end
				end
			end

			// Coefficient walk: own range, then upward, then downward; with an invalid range, downward from the last range.
			if (issue_coef) begin
				cph_q <= cph_d;
				cr_q  <= cr_d;
			end
			if (state_q == ST_COEF && rd_v_s1 && cmp.match && !hit_q) begin
				hit_q  <= 1'b1;
				coef_q <= rd_data_s1.coef;
			end

			if (out_load)
				ov_q <= 1'b1;
			else if (out_ch.ready)
				ov_q <= 1'b0;
		end
	end
endmodule

[rtl/macs_cmp.sv]
module macs_cmp import macs_pkg::*; #(
	parameter int DEAD_BAND = 3
) (
	input  cal_entry_t  entry,
	input  logic [2:0]  want_gear,
	input  logic [11:0] code,
	input  logic [11:0] prev_code,
	output cmp_res_t    res
);
	localparam logic [13:0] DB2 = 14'(2 * DEAD_BAND);

	logic [13:0] sum;
	logic [13:0] code2;

	assign sum   = 14'(prev_code) + 14'(entry.code) + DB2;
	assign code2 = {1'b0, code, 1'b0};

	always_comb begin
		res.match    = (entry.gear == want_gear);
		res.in_seg   = (prev_code >= code) && (code >= entry.code);
		// Below the midpoint plus the dead band the lower point wins.
		res.take_cur = (code2 < sum);
	end
endmodule

[rtl/macs_chk.sv]
module macs_chk import macs_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic [1:0] in_op,
	input logic       out_valid,
	input logic       out_ready
);
	// A result waits until it is taken.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped before it was taken");

	// A sample keeps the block busy for at least the next cycle.
	a_sample_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_op == OP_SAMPLE |=> !in_ready)
		else $error("block ready right after a sample");

	// Ticks, loads and unknown codes leave the block ready in the next cycle.
	a_short_op: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_op != OP_SAMPLE |=> in_ready)
		else $error("block busy after a one-cycle transaction");

	// A new result appears only at the end of a sample.
	a_out_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!in_ready))
		else $error("result without a sample in work");
endmodule

bind meter_autorange_calibration_select macs_chk u_macs_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_ch.valid),
	.in_ready  (in_ch.ready),
	.in_op     (in_ch.payload.operation),
	.out_valid (out_ch.valid),
	.out_ready (out_ch.ready)
);
